/* src/rtcc_pkg.sv */
// Shared types, constants and fixed-point formats of the RGB to CCT pipeline.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rtcc_pkg;

  localparam int CH_W   = 16;  // raw channel count
  localparam int COEF_W = 18;  // signed Q.16 matrix coefficient
  localparam int T_W    = 34;  // tristimulus X, Y, Z, signed Q.16
  localparam int S_W    = 36;  // X+Y+Z, signed Q.16

  // Divider: dividend magnitude, divisor magnitude, quotient bits
  localparam int DIV_NW = 49;
  localparam int DIV_DW = 35;
  localparam int DIV_QW = 32;
  localparam int DIV_RW = DIV_DW + DIV_QW;

  localparam int XY_W   = 33;  // chromaticity and McCamy terms, signed Q.16
  localparam int N_W    = 23;  // clamped n, signed Q.16
  localparam int SUM_W  = 44;  // cubic sum, signed Q.16

  localparam logic signed [COEF_W-1:0] MAT [3][3] = '{
    '{-18'sd9360,  18'sd101531, -18'sd62679},
    '{-18'sd21277, 18'sd103440, -18'sd47966},
    '{-18'sd44697, 18'sd50511,   18'sd36918}
  };

  localparam logic signed [XY_W-1:0]  K_X0 = 33'sd21758;      // 0.3320
  localparam logic signed [XY_W-1:0]  K_Y0 = 33'sd12177;      // 0.1858
  localparam logic signed [10:0]      K_C3 = 11'sd449;
  localparam logic signed [12:0]      K_C2 = 13'sd3525;
  localparam logic signed [29:0]      K_C1 = 30'sd447171789;  // 6823.3
  localparam logic signed [SUM_W-1:0] K_C0 = 44'sd361780347;  // 5520.33

  localparam logic [DIV_QW-1:0] XYC_LIM = 32'h8000_0000;  // 32768.0
  localparam logic [DIV_QW-1:0] N_LIM   = 32'h0020_0000;  // 32.0

  localparam logic [1:0] FAULT_OK  = 2'd0;
  localparam logic [1:0] FAULT_SUM = 2'd1;
  localparam logic [1:0] FAULT_DEN = 2'd2;

  // Sideband that rides along the datapath
  typedef struct packed {
    logic [CH_W-1:0] lux;
    logic            lclip;
    logic [1:0]      fault;
  } side_t;

  // Sign-magnitude quotient; ovf means magnitude >= 2^DIV_QW
  typedef struct packed {
    logic              neg;
    logic              ovf;
    logic [DIV_QW-1:0] mag;
  } quot_t;

endpackage

/* src/rtcc_mat.sv */
// Color matrix stages: RGB counts to X, Y, Z, their sum and the lux value.
// Depends on rtcc_pkg.
`timescale 1ns / 1ps

module rtcc_mat (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [rtcc_pkg::CH_W-1:0]    red_i,
  input  logic [rtcc_pkg::CH_W-1:0]    green_i,
  input  logic [rtcc_pkg::CH_W-1:0]    blue_i,
  output logic                         valid_o,
  output logic signed [rtcc_pkg::T_W-1:0] tx_o,
  output logic signed [rtcc_pkg::T_W-1:0] ty_o,
  output logic signed [rtcc_pkg::S_W-1:0] sum_o,
  output rtcc_pkg::side_t              side_o
);
  import rtcc_pkg::*;

  logic [2:0] v_q;
  logic [CH_W-1:0] ch [3];
  logic signed [T_W+COEF_W-CH_W:0] prod_full [3][3];
  logic signed [T_W-1:0] prod_q [3][3];
  logic signed [T_W-1:0] t_d [3];
  logic signed [T_W-1:0] t_q [3];
  logic signed [S_W-1:0] s_d, s_q;
  logic signed [T_W-1:0] tx_q, ty_q;
  side_t side_d, side_q;

  assign ch[0] = red_i;
  assign ch[1] = green_i;
  assign ch[2] = blue_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_full[i][j] = MAT[i][j] * $signed({1'b0, ch[j]});
      end
      t_d[i] = prod_q[i][0] + prod_q[i][1] + prod_q[i][2];
    end
  end

  // lux = Y truncated toward zero, saturated
  always_comb begin
    s_d = S_W'(t_q[0]) + S_W'(t_q[1]) + S_W'(t_q[2]);
    side_d.fault = (s_d == '0) ? FAULT_SUM : FAULT_OK;
    side_d.lclip = 1'b0;
    if (t_q[1] < -34'sd65535) begin
      side_d.lux   = '0;
      side_d.lclip = 1'b1;
    end else if (t_q[1] >= 34'sd4294967296) begin
      side_d.lux   = '1;
      side_d.lclip = 1'b1;
    end else if (t_q[1] < 0) begin
      side_d.lux = '0;
    end else begin
      side_d.lux = t_q[1][31:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[i][j] <= prod_full[i][j][T_W-1:0];
        end
        t_q[i] <= t_d[i];
      end
      s_q    <= s_d;
      tx_q   <= t_q[0];
      ty_q   <= t_q[1];
      side_q <= side_d;
    end
  end

  assign valid_o = v_q[2];
  assign tx_o    = tx_q;
  assign ty_o    = ty_q;
  assign sum_o   = s_q;
  assign side_o  = side_q;

endmodule

/* src/rtcc_div.sv */
// Pipelined two-lane restoring divider, shared divisor, one quotient bit per stage.
// Depends on rtcc_pkg.
`timescale 1ns / 1ps

module rtcc_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [rtcc_pkg::DIV_NW:0]  num_a_i,
  input  logic signed [rtcc_pkg::DIV_NW:0]  num_b_i,
  input  logic signed [rtcc_pkg::DIV_DW:0]  den_i,
  input  rtcc_pkg::side_t                   side_i,
  output logic                              valid_o,
  output rtcc_pkg::quot_t                   quot_a_o,
  output rtcc_pkg::quot_t                   quot_b_o,
  output rtcc_pkg::side_t                   side_o
);
  import rtcc_pkg::*;

  localparam int NST = DIV_QW + 1;  // setup stage plus one per quotient bit

  logic [NST-1:0]    v_q;
  logic [DIV_NW-1:0] ra_q [NST];
  logic [DIV_NW-1:0] rb_q [NST];
  logic [DIV_NW-1:0] ra_d [NST];
  logic [DIV_NW-1:0] rb_d [NST];
  logic [DIV_QW-1:0] qa_q [NST];
  logic [DIV_QW-1:0] qb_q [NST];
  logic [DIV_QW-1:0] qa_d [NST];
  logic [DIV_QW-1:0] qb_d [NST];
  logic [DIV_DW-1:0] d_q  [NST];
  logic [NST-1:0]    nega_q, negb_q, ovfa_q, ovfb_q;
  side_t             side_q [NST];

  logic [DIV_NW:0]   abs_a, abs_b;
  logic [DIV_DW:0]   abs_d;
  logic [DIV_RW-1:0] dtop, dsh;
  logic              gea, geb;

  // setup: magnitudes and out-of-range check against d * 2^QW
  always_comb begin
    abs_a = num_a_i[DIV_NW] ? (DIV_NW+1)'(-num_a_i) : num_a_i;
    abs_b = num_b_i[DIV_NW] ? (DIV_NW+1)'(-num_b_i) : num_b_i;
    abs_d = den_i[DIV_DW] ? (DIV_DW+1)'(-den_i) : den_i;
    dtop  = {abs_d[DIV_DW-1:0], {DIV_QW{1'b0}}};
    ra_d[0] = abs_a[DIV_NW-1:0];
    rb_d[0] = abs_b[DIV_NW-1:0];
    qa_d[0] = '0;
    qb_d[0] = '0;
    dsh = '0;
    gea = 1'b0;
    geb = 1'b0;
    for (int j = 1; j < NST; j++) begin
      dsh = {{DIV_QW{1'b0}}, d_q[j-1]} << (DIV_QW - j);
      gea = {{(DIV_RW-DIV_NW){1'b0}}, ra_q[j-1]} >= dsh;
      geb = {{(DIV_RW-DIV_NW){1'b0}}, rb_q[j-1]} >= dsh;
      ra_d[j] = gea ? ra_q[j-1] - dsh[DIV_NW-1:0] : ra_q[j-1];
      rb_d[j] = geb ? rb_q[j-1] - dsh[DIV_NW-1:0] : rb_q[j-1];
      qa_d[j] = {qa_q[j-1][DIV_QW-2:0], gea};
      qb_d[j] = {qb_q[j-1][DIV_QW-2:0], geb};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ra_q[0]   <= ra_d[0];
      rb_q[0]   <= rb_d[0];
      qa_q[0]   <= qa_d[0];
      qb_q[0]   <= qb_d[0];
      d_q[0]    <= abs_d[DIV_DW-1:0];
      nega_q[0] <= num_a_i[DIV_NW] ^ den_i[DIV_DW];
      negb_q[0] <= num_b_i[DIV_NW] ^ den_i[DIV_DW];
      ovfa_q[0] <= {{(DIV_RW-DIV_NW){1'b0}}, abs_a[DIV_NW-1:0]} >= dtop;
      ovfb_q[0] <= {{(DIV_RW-DIV_NW){1'b0}}, abs_b[DIV_NW-1:0]} >= dtop;
      side_q[0] <= side_i;
      for (int j = 1; j < NST; j++) begin
        ra_q[j]   <= ra_d[j];
        rb_q[j]   <= rb_d[j];
        qa_q[j]   <= qa_d[j];
        qb_q[j]   <= qb_d[j];
        d_q[j]    <= d_q[j-1];
        nega_q[j] <= nega_q[j-1];
        negb_q[j] <= negb_q[j-1];
        ovfa_q[j] <= ovfa_q[j-1];
        ovfb_q[j] <= ovfb_q[j-1];
        side_q[j] <= side_q[j-1];
      end
    end
  end

  assign valid_o  = v_q[NST-1];
  assign quot_a_o = '{neg: nega_q[NST-1], ovf: ovfa_q[NST-1], mag: qa_q[NST-1]};
  assign quot_b_o = '{neg: negb_q[NST-1], ovf: ovfb_q[NST-1], mag: qb_q[NST-1]};
  assign side_o   = side_q[NST-1];

endmodule

/* src/rtcc_poly.sv */
// McCamy cubic stages: clamp n, form n^2, n^3 and the Q.16 sum.
// Depends on rtcc_pkg.
`timescale 1ns / 1ps

module rtcc_poly (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  rtcc_pkg::quot_t                    quot_i,
  input  rtcc_pkg::side_t                    side_i,
  output logic                               valid_o,
  output logic signed [rtcc_pkg::SUM_W-1:0]  sum_o,
  output rtcc_pkg::side_t                    side_o
);
  import rtcc_pkg::*;

  logic [5:0] v_q;
  side_t side_q [6];

  // stage A: clamp to +-32.0
  logic [DIV_QW-1:0]     nmag;
  logic signed [N_W-1:0] n_d, na_q, nb_q, nc_q;
  // stage B
  logic signed [2*N_W-1:0] nn_full;
  logic [42:0]             nn_q;
  logic signed [52:0]      c1n_full;
  logic signed [51:0]      c1n_q, c1n_adj;
  // stage C
  logic [26:0]        n2_q, n2d_q;
  logic signed [35:0] c1t_q, c1td_q, c1te_q;
  // stage D
  logic signed [50:0] n2n_full, n2n_q, n2n_adj;
  // stage E
  logic signed [34:0]      n3;
  logic signed [45:0]      p3_full;
  logic signed [40:0]      p2_full;
  logic signed [SUM_W-1:0] p3_q, p2_q, sum_q;

  always_comb begin
    nmag     = (quot_i.ovf || quot_i.mag > N_LIM) ? N_LIM : quot_i.mag;
    n_d      = quot_i.neg ? -$signed({1'b0, nmag[N_W-2:0]}) : $signed({1'b0, nmag[N_W-2:0]});
    nn_full  = na_q * na_q;
    c1n_full = K_C1 * na_q;
    c1n_adj  = c1n_q + (c1n_q[51] ? 52'sd65535 : 52'sd0);
    n2n_full = $signed({1'b0, n2_q}) * nc_q;
    n2n_adj  = n2n_q + (n2n_q[50] ? 51'sd65535 : 51'sd0);
    n3       = n2n_adj[50:16];
    p3_full  = K_C3 * n3;
    p2_full  = K_C2 * $signed({1'b0, n2d_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      na_q   <= n_d;
      nn_q   <= nn_full[42:0];
      c1n_q  <= c1n_full[51:0];
      nb_q   <= na_q;
      n2_q   <= nn_q[42:16];
      c1t_q  <= c1n_adj[51:16];
      nc_q   <= nb_q;
      n2n_q  <= n2n_full;
      n2d_q  <= n2_q;
      c1td_q <= c1t_q;
      p3_q   <= p3_full[SUM_W-1:0];
      p2_q   <= SUM_W'(p2_full);
      c1te_q <= c1td_q;
      sum_q  <= p3_q + p2_q + SUM_W'(c1te_q) + K_C0;
      side_q[0] <= side_i;
      for (int k = 1; k < 6; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = v_q[5];
  assign sum_o   = sum_q;
  assign side_o  = side_q[5];

endmodule

/* src/rgb_to_color_temperature.sv */
// Top level of the RGB to correlated color temperature and lux pipeline.
// Depends on rtcc_pkg, rtcc_mat, rtcc_div and rtcc_poly.
`timescale 1ns / 1ps

// Usage:
//  Slave stream takes one raw red/green/blue triple per beat; master stream
//  gives one result beat per input beat, in order: kelvin, illuminance (lux),
//  fault code and a clipped flag.
//  From an accepted input beat to tvalid on the output a beat passes through
//  3 matrix stages, two 33-stage dividers (X/S and Y/S share one, McCamy's
//  ratio has the other), one chromaticity stage, 6 cubic stages and the
//  output register.
//  Throughput is one beat per cycle while the skid register is empty: every
//  stage is registered and the dividers resolve one quotient bit per stage.
//  Reset clears all valid bits; the pipeline comes up empty and ready.
//  When the receiver stalls, the output register holds its beat and one
//  more finished beat drops into a skid register; only while that skid
//  register is full is s_axis_tready low and the whole pipeline frozen.
//  Faults: zero X+Y+Z gives fault 1, zero McCamy denominator fault 2; kelvin
//  is then 0 and illuminance is still valid.

module rgb_to_color_temperature (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // red[15:0], green[31:16], blue[47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // kelvin[15:0], illuminance[31:16], fault[33:32], clipped[34], zero[39:35]
  output logic [39:0] m_axis_tdata
);
  import rtcc_pkg::*;

  logic en;  // global advance: pipeline moves unless skid is occupied

  // matrix stage outputs
  logic                  mat_v;
  logic signed [T_W-1:0] tx, ty;
  logic signed [S_W-1:0] tsum;
  side_t                 mat_side;

  // chromaticity divider
  logic  d1_v;
  quot_t xq, yq;
  side_t d1_side;

  // McCamy numerator / denominator stage
  logic [DIV_QW-1:0]      xm, ym;
  logic signed [XY_W-1:0] xc, yc, num_d, den_d, num_q, den_q;
  side_t                  c_side_d, c_side_q;
  logic                   c_v_q;

  // ratio divider
  logic  d2_v;
  quot_t nq, unused_q;
  side_t d2_side;

  // cubic
  logic                    p_v;
  logic signed [SUM_W-1:0] p_sum;
  side_t                   p_side;

  // final saturation
  logic [15:0] kel_d;
  logic        kclip_d;
  logic [39:0] fin_d;

  // output register and skid
  logic        out_v_q, skid_v_q;
  logic [39:0] out_q, skid_q;

  assign en            = ~skid_v_q;
  assign s_axis_tready = en;

  rtcc_mat u_mat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .red_i   (s_axis_tdata[15:0]),
    .green_i (s_axis_tdata[31:16]),
    .blue_i  (s_axis_tdata[47:32]),
    .valid_o (mat_v),
    .tx_o    (tx),
    .ty_o    (ty),
    .sum_o   (tsum),
    .side_o  (mat_side)
  );

  // xc = X * 2^16 / S, yc = Y * 2^16 / S
  rtcc_div u_div_xy (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (mat_v),
    .num_a_i  ({tx, 16'b0}),
    .num_b_i  ({ty, 16'b0}),
    .den_i    (tsum),
    .side_i   (mat_side),
    .valid_o  (d1_v),
    .quot_a_o (xq),
    .quot_b_o (yq),
    .side_o   (d1_side)
  );

  // clamp chromaticity to +-32768.0, then McCamy's numerator and denominator
  always_comb begin
    xm    = (xq.ovf || xq.mag > XYC_LIM) ? XYC_LIM : xq.mag;
    ym    = (yq.ovf || yq.mag > XYC_LIM) ? XYC_LIM : yq.mag;
    xc    = xq.neg ? -$signed({1'b0, xm}) : $signed({1'b0, xm});
    yc    = yq.neg ? -$signed({1'b0, ym}) : $signed({1'b0, ym});
    num_d = xc - K_X0;
    den_d = K_Y0 - yc;
    c_side_d = d1_side;
    if (d1_side.fault == FAULT_OK && den_d == '0) begin
      c_side_d.fault = FAULT_DEN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en) begin
      c_v_q <= d1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q    <= num_d;
      den_q    <= den_d;
      c_side_q <= c_side_d;
    end
  end

  // n = num * 2^16 / den; lane b is idle
  rtcc_div u_div_n (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (c_v_q),
    .num_a_i  ({num_q[XY_W-1], num_q, 16'b0}),
    .num_b_i  ('0),
    .den_i    ((DIV_DW+1)'(den_q)),
    .side_i   (c_side_q),
    .valid_o  (d2_v),
    .quot_a_o (nq),
    .quot_b_o (unused_q),
    .side_o   (d2_side)
  );

  rtcc_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d2_v),
    .quot_i  (nq),
    .side_i  (d2_side),
    .valid_o (p_v),
    .sum_o   (p_sum),
    .side_o  (p_side)
  );

  // kelvin = sum / 2^16 toward zero, saturated; forced to 0 on any fault
  always_comb begin
    kclip_d = 1'b0;
    if (p_side.fault != FAULT_OK) begin
      kel_d = '0;
    end else if (p_sum < -44'sd65535) begin
      kel_d   = '0;
      kclip_d = 1'b1;
    end else if (p_sum >= 44'sd4294967296) begin
      kel_d   = '1;
      kclip_d = 1'b1;
    end else if (p_sum < 0) begin
      kel_d = '0;
    end else begin
      kel_d = p_sum[31:16];
    end
    fin_d = {5'b0, kclip_d | p_side.lclip, p_side.fault, p_side.lux, kel_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (m_axis_tready || !out_v_q) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= p_v;
      end
    end else if (p_v && en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_axis_tready || !out_v_q) begin
      out_q <= skid_v_q ? skid_q : fin_d;
    end else if (p_v && en) begin
      skid_q <= fin_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  // skid only fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid full with output empty");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !m_axis_tready |=> out_v_q && $stable(out_q))
    else $error("held output beat changed");

  a_fault_kelvin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q[33:32] != FAULT_OK |-> out_q[15:0] == '0)
    else $error("kelvin not zero on fault");

  a_fault_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> out_q[33:32] != 2'd3) else $error("undefined fault code");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |=> $stable(p_sum) || !skid_v_q) else $error("pipe moved while frozen");

endmodule
